/* rtl/core/hrp_pkg.sv */
`default_nettype none

package hrp_pkg;

  // reset value of the record mark: ascii colon
  localparam logic [7:0] RECORD_MARK_RESET = 8'd58;

  // bytes in front of the data: length, offset high, offset low, type
  localparam int unsigned HEADER_BYTES = 4;

  // depth of the token queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // classified character handed from front to back
  typedef struct packed {
    logic       is_mark;
    logic [3:0] nibble;
  } token_t;

  // hex digit value, anything else counts as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h57;
      end
      nibble_of = d[3:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/hex_record_parser_top.sv */
// a result is registered twice after its last character transfer: in the token queue, then in the output register
// throughput: one character per cycle while out_stall is low; in_stall is raised when the token queue is full
// a two-entry token queue lets the front keep taking characters while a result is stalled
// reset: synchronous, active high; clears the queue, the parser state and the output valid,
// and restores the record mark to a colon
`default_nettype none

module hex_record_parser_top #(
  parameter int unsigned QUEUE_DEPTH = hrp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       data_byte,
  output logic [7:0]       byte_index,
  output logic [7:0]       record_length,
  output logic [15:0]      load_offset,
  output logic [7:0]       record_type,
  output logic             checksum_ok
);

  hrp_pkg::token_t front_tok;
  hrp_pkg::token_t back_tok;
  logic            q_full;
  logic            q_avail;
  logic            q_pop;
  logic            q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // character classification
  hrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .char_code (char_code),
    .tok       (front_tok)
  );

  // token queue between front and back
  hrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (front_tok),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_tok  (back_tok)
  );

  // record parsing and result register
  hrp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (q_avail),
    .tok           (back_tok),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .record_length (record_length),
    .load_offset   (load_offset),
    .record_type   (record_type),
    .checksum_ok   (checksum_ok)
  );

endmodule

`default_nettype wire

/* rtl/core/hrp_front.sv */
`default_nettype none

module hrp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [7:0]    cfg_data,
  input  wire logic [7:0]    char_code,
  output hrp_pkg::token_t    tok
);

  logic [7:0] record_mark;

  // record mark register
  always_ff @(posedge clk) begin
    if (rst) begin
      record_mark <= hrp_pkg::RECORD_MARK_RESET;
    end else if (cfg_write) begin
      record_mark <= cfg_data;
    end
  end

  // classify the incoming character
  always_comb begin
    tok.is_mark = (char_code == record_mark);
    tok.nibble  = hrp_pkg::nibble_of(char_code);
  end

endmodule

`default_nettype wire

/* rtl/core/hrp_queue.sv */
`default_nettype none

module hrp_queue #(
  parameter int unsigned DEPTH = hrp_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire hrp_pkg::token_t push_tok,
  output logic               full,
  input  wire logic          pop,
  output logic               avail,
  output hrp_pkg::token_t    pop_tok
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hrp_pkg::token_t entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign avail   = (count != '0);
  assign pop_tok = entries[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/hrp_back.sv */
`default_nettype none

module hrp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          avail,
  input  wire hrp_pkg::token_t tok,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               kind,
  output logic [7:0]         data_byte,
  output logic [7:0]         byte_index,
  output logic [7:0]         record_length,
  output logic [15:0]        load_offset,
  output logic [7:0]         record_type,
  output logic               checksum_ok
);

  logic        receiving, receiving_next;
  logic [9:0]  char_count, char_count_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  length_value, length_value_next;
  logic [15:0] offset_value, offset_value_next;
  logic [7:0]  type_value, type_value_next;
  logic [7:0]  byte_sum, byte_sum_next;

  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data;
  logic [7:0]  res_index;
  logic        res_ok;

  logic [7:0]  value;
  logic [7:0]  sum_new;
  logic [8:0]  bidx;
  logic [8:0]  data_end;
  logic [8:0]  data_pos;

  // output register free or being drained
  assign pop = avail && (!out_valid || !out_stall);

  assign value    = {high_nibble, tok.nibble};
  assign sum_new  = byte_sum + value;
  assign bidx     = char_count[9:1];
  assign data_end = 9'(hrp_pkg::HEADER_BYTES) + {1'b0, length_value};
  assign data_pos = bidx - 9'(hrp_pkg::HEADER_BYTES);

  // record parsing step
  always_comb begin
    receiving_next    = receiving;
    char_count_next   = char_count;
    high_nibble_next  = high_nibble;
    length_value_next = length_value;
    offset_value_next = offset_value;
    type_value_next   = type_value;
    byte_sum_next     = byte_sum;
    res_valid         = 1'b0;
    res_kind          = hrp_pkg::KIND_DATA;
    res_data          = 8'd0;
    res_index         = 8'd0;
    res_ok            = 1'b0;
    if (tok.is_mark) begin
      receiving_next    = 1'b1;
      char_count_next   = '0;
      high_nibble_next  = '0;
      length_value_next = '0;
      offset_value_next = '0;
      type_value_next   = '0;
      byte_sum_next     = '0;
    end else if (receiving) begin
      char_count_next = char_count + 10'd1;
      if (!char_count[0]) begin
        high_nibble_next = tok.nibble;
      end else begin
        byte_sum_next = sum_new;
        if (bidx == 9'd0) begin
          length_value_next = value;
        end else if (bidx == 9'd1) begin
          offset_value_next = {value, 8'd0};
        end else if (bidx == 9'd2) begin
          offset_value_next = {offset_value[15:8], value};
        end else if (bidx == 9'd3) begin
          type_value_next = value;
        end else if (bidx < data_end) begin
          res_valid = 1'b1;
          res_data  = value;
          res_index = data_pos[7:0];
        end else begin
          // checksum byte closes the record
          res_valid       = 1'b1;
          res_kind        = hrp_pkg::KIND_SUMMARY;
          res_ok          = (sum_new == 8'd0);
          receiving_next  = 1'b0;
          char_count_next = '0;
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      receiving    <= 1'b0;
      char_count   <= '0;
      high_nibble  <= '0;
      length_value <= '0;
      offset_value <= '0;
      type_value   <= '0;
      byte_sum     <= '0;
    end else if (pop) begin
      receiving    <= receiving_next;
      char_count   <= char_count_next;
      high_nibble  <= high_nibble_next;
      length_value <= length_value_next;
      offset_value <= offset_value_next;
      type_value   <= type_value_next;
      byte_sum     <= byte_sum_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind          <= res_kind;
      data_byte     <= res_data;
      byte_index    <= res_index;
      record_length <= length_value;
      load_offset   <= offset_value;
      record_type   <= type_value;
      checksum_ok   <= res_ok;
    end
  end

endmodule

`default_nettype wire
